@@ sv/spq_pkg.sv @@
// ----------------------------------------------------------------------------
// spq_pkg
// Shared types and constants of the sorted priority queue.
// ----------------------------------------------------------------------------
package spq_pkg;

    localparam int DEPTH_DEF = 16;
    localparam int MODE_W    = 2;
    localparam int CODE_W    = 16;
    localparam int PRIO_W    = 8;
    localparam int STATUS_W  = 2;

    typedef enum logic [MODE_W-1:0] {
        MODE_INSERT = 2'd0,
        MODE_REMOVE = 2'd1,
        MODE_READ   = 2'd2,
        MODE_IGNORE = 2'd3
    } mode_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } status_t;

    typedef enum logic {
        S_IDLE = 1'b0,
        S_READ = 1'b1
    } state_t;

    typedef enum logic [2:0] {
        OP_NONE       = 3'd0,
        OP_INSERT     = 3'd1,
        OP_POP        = 3'd2,
        OP_READ_START = 3'd3,
        OP_ROTATE     = 3'd4
    } op_t;

    typedef struct packed {
        op_t     op;
        logic    load_out;
        logic    out_head;
        status_t st;
        logic    last;
    } cmd_t;

    typedef struct packed {
        logic empty;
        logic full;
        logic read_last;
    } stat_t;

endpackage

@@ sv/spq_req_if.sv @@
// ----------------------------------------------------------------------------
// spq_req_if
// Request channel: mode and entry to insert, valid/ready handshake.
// ----------------------------------------------------------------------------
interface spq_req_if;
    logic                          valid;
    logic                          ready;
    logic [spq_pkg::MODE_W-1:0]    mode;
    logic [spq_pkg::CODE_W-1:0]    item_code;
    logic [spq_pkg::PRIO_W-1:0]    item_priority;

    modport source (
        output valid,
        output mode,
        output item_code,
        output item_priority,
        input  ready
    );

    modport sink (
        input  valid,
        input  mode,
        input  item_code,
        input  item_priority,
        output ready
    );
endinterface

@@ sv/spq_rsp_if.sv @@
// ----------------------------------------------------------------------------
// spq_rsp_if
// Result channel: entry, status and last flag, valid/ready handshake.
// ----------------------------------------------------------------------------
interface spq_rsp_if;
    logic                          valid;
    logic                          ready;
    logic [spq_pkg::CODE_W-1:0]    out_code;
    logic [spq_pkg::PRIO_W-1:0]    out_priority;
    logic [spq_pkg::STATUS_W-1:0]  status;
    logic                          last;

    modport source (
        output valid,
        output out_code,
        output out_priority,
        output status,
        output last,
        input  ready
    );

    modport sink (
        input  valid,
        input  out_code,
        input  out_priority,
        input  status,
        input  last,
        output ready
    );
endinterface

@@ sv/sorted_priority_queue.sv @@
// ----------------------------------------------------------------------------
// sorted_priority_queue
// Priority queue kept sorted by ascending priority in a shifting cell chain.
// ----------------------------------------------------------------------------
// insert and remove give their result in the cycle after the request
// read-out: entries leave from S_READ, one per cycle while the result is taken
// throughput: 1 insert/remove per cycle while results are taken; none in read-out
// reset: entry count cleared and result channel empty; cell contents not cleared
module sorted_priority_queue #(
    parameter int DEPTH = spq_pkg::DEPTH_DEF
) (
    input  logic      clk,
    input  logic      rst_n,
    spq_req_if.sink   request,
    spq_rsp_if.source result
);

    spq_pkg::cmd_t  cmd;
    spq_pkg::stat_t stat;

    spq_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (request.valid),
        .in_mode   (request.mode),
        .in_ready  (request.ready),
        .out_valid (result.valid),
        .out_ready (result.ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    spq_datapath #(
        .DEPTH (DEPTH)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .in_code      (request.item_code),
        .in_prio      (request.item_priority),
        .stat         (stat),
        .out_code     (result.out_code),
        .out_priority (result.out_priority),
        .out_status   (result.status),
        .out_last     (result.last)
    );

endmodule

@@ sv/spq_ctrl.sv @@
// ----------------------------------------------------------------------------
// spq_ctrl
// Controller: request decode, read-out sequencing and result valid flag.
// ----------------------------------------------------------------------------
module spq_ctrl (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    input  logic [spq_pkg::MODE_W-1:0]  in_mode,
    output logic                        in_ready,
    output logic                        out_valid,
    input  logic                        out_ready,
    input  spq_pkg::stat_t              stat,
    output spq_pkg::cmd_t               cmd
);

    spq_pkg::state_t state_reg;
    spq_pkg::state_t state_next;
    logic            out_valid_reg;
    logic            out_valid_next;
    logic            out_free;
    logic            accept;

    assign out_free  = !out_valid_reg || out_ready;
    assign in_ready  = (state_reg == spq_pkg::S_IDLE) && out_free;
    assign accept    = in_valid && in_ready;
    assign out_valid = out_valid_reg;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            spq_pkg::S_IDLE:
            begin
                if (accept && (spq_pkg::mode_t'(in_mode) == spq_pkg::MODE_READ)
                    && !stat.empty)
                begin
                    state_next = spq_pkg::S_READ;
                end
            end
            spq_pkg::S_READ:
            begin
                if (out_free && stat.read_last)
                begin
                    state_next = spq_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = spq_pkg::S_IDLE;
            end
        endcase
    end

    // commands
    always_comb
    begin
        cmd.op       = spq_pkg::OP_NONE;
        cmd.load_out = 1'b0;
        cmd.out_head = 1'b0;
        cmd.st       = spq_pkg::ST_OK;
        cmd.last     = 1'b1;
        case (state_reg)
            spq_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    case (spq_pkg::mode_t'(in_mode))
                        spq_pkg::MODE_INSERT:
                        begin
                            cmd.load_out = 1'b1;
                            cmd.st       = stat.full ? spq_pkg::ST_FULL : spq_pkg::ST_OK;
                            cmd.op       = stat.full ? spq_pkg::OP_NONE : spq_pkg::OP_INSERT;
                        end
                        spq_pkg::MODE_REMOVE:
                        begin
                            cmd.load_out = 1'b1;
                            cmd.out_head = !stat.empty;
                            cmd.st       = stat.empty ? spq_pkg::ST_EMPTY : spq_pkg::ST_OK;
                            cmd.op       = stat.empty ? spq_pkg::OP_NONE : spq_pkg::OP_POP;
                        end
                        spq_pkg::MODE_READ:
                        begin
                            if (stat.empty)
                            begin
                                cmd.load_out = 1'b1;
                                cmd.st       = spq_pkg::ST_EMPTY;
                            end
                            else
                            begin
                                cmd.op = spq_pkg::OP_READ_START;
                            end
                        end
                        default:
                        begin
                            cmd.op = spq_pkg::OP_NONE;
                        end
                    endcase
                end
            end
            spq_pkg::S_READ:
            begin
                if (out_free)
                begin
                    cmd.op       = spq_pkg::OP_ROTATE;
                    cmd.load_out = 1'b1;
                    cmd.out_head = 1'b1;
                    cmd.last     = stat.read_last;
                end
            end
            default:
            begin
                cmd.op = spq_pkg::OP_NONE;
            end
        endcase
    end

    always_comb
    begin
        if (cmd.load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= spq_pkg::S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

`ifndef SYNTH
    a_no_accept_in_read: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == spq_pkg::S_READ) |-> !in_ready)
        else $error("request accepted during read-out");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_ready) |-> !cmd.load_out)
        else $error("pending result overwritten");
`endif

endmodule

@@ sv/spq_datapath.sv @@
// ----------------------------------------------------------------------------
// spq_datapath
// Shifting cell chain of entries, entry count, read-out counter and
// result register.
// ----------------------------------------------------------------------------
module spq_datapath #(
    parameter int DEPTH = spq_pkg::DEPTH_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  spq_pkg::cmd_t                 cmd,
    input  logic [spq_pkg::CODE_W-1:0]    in_code,
    input  logic [spq_pkg::PRIO_W-1:0]    in_prio,
    output spq_pkg::stat_t                stat,
    output logic [spq_pkg::CODE_W-1:0]    out_code,
    output logic [spq_pkg::PRIO_W-1:0]    out_priority,
    output logic [spq_pkg::STATUS_W-1:0]  out_status,
    output logic                          out_last
);

    localparam int CW = $clog2(DEPTH + 1);

    logic [spq_pkg::CODE_W-1:0]   code_reg  [DEPTH];
    logic [spq_pkg::CODE_W-1:0]   code_next [DEPTH];
    logic [spq_pkg::PRIO_W-1:0]   prio_reg  [DEPTH];
    logic [spq_pkg::PRIO_W-1:0]   prio_next [DEPTH];
    logic [DEPTH-1:0]             keep;
    logic [CW-1:0]                count_reg;
    logic [CW-1:0]                count_next;
    logic [CW-1:0]                remain_reg;
    logic [CW-1:0]                remain_next;
    logic [spq_pkg::CODE_W-1:0]   out_code_reg;
    logic [spq_pkg::PRIO_W-1:0]   out_prio_reg;
    logic [spq_pkg::STATUS_W-1:0] out_status_reg;
    logic                         out_last_reg;

    assign stat.empty     = (count_reg == '0);
    assign stat.full      = (count_reg == CW'(DEPTH));
    assign stat.read_last = (remain_reg == CW'(1));

    // cells that stay put on insert: occupied and priority not greater
    always_comb
    begin
        for (int i = 0; i < DEPTH; i++)
        begin
            keep[i] = (CW'(i) < count_reg) && (prio_reg[i] <= in_prio);
        end
    end

    always_comb
    begin
        for (int i = 0; i < DEPTH; i++)
        begin
            code_next[i] = code_reg[i];
            prio_next[i] = prio_reg[i];
            case (cmd.op)
                spq_pkg::OP_INSERT:
                begin
                    if (!keep[i])
                    begin
                        if (i == 0)
                        begin
                            code_next[i] = in_code;
                            prio_next[i] = in_prio;
                        end
                        else if (keep[(i == 0) ? 0 : i - 1])
                        begin
                            code_next[i] = in_code;
                            prio_next[i] = in_prio;
                        end
                        else
                        begin
                            code_next[i] = code_reg[(i == 0) ? 0 : i - 1];
                            prio_next[i] = prio_reg[(i == 0) ? 0 : i - 1];
                        end
                    end
                end
                spq_pkg::OP_POP:
                begin
                    if (i < DEPTH - 1)
                    begin
                        code_next[i] = code_reg[(i < DEPTH - 1) ? i + 1 : i];
                        prio_next[i] = prio_reg[(i < DEPTH - 1) ? i + 1 : i];
                    end
                end
                spq_pkg::OP_ROTATE:
                begin
                    // head wraps around to the tail slot
                    if (CW'(i + 1) == count_reg)
                    begin
                        code_next[i] = code_reg[0];
                        prio_next[i] = prio_reg[0];
                    end
                    else if (i < DEPTH - 1)
                    begin
                        code_next[i] = code_reg[(i < DEPTH - 1) ? i + 1 : i];
                        prio_next[i] = prio_reg[(i < DEPTH - 1) ? i + 1 : i];
                    end
                end
                default:
                begin
                    code_next[i] = code_reg[i];
                    prio_next[i] = prio_reg[i];
                end
            endcase
        end
    end

    always_comb
    begin
        count_next  = count_reg;
        remain_next = remain_reg;
        case (cmd.op)
            spq_pkg::OP_INSERT:    count_next  = count_reg + CW'(1);
            spq_pkg::OP_POP:       count_next  = count_reg - CW'(1);
            spq_pkg::OP_READ_START: remain_next = count_reg;
            spq_pkg::OP_ROTATE:    remain_next = remain_reg - CW'(1);
            default:
            begin
                count_next  = count_reg;
                remain_next = remain_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < DEPTH; i++)
        begin
            code_reg[i] <= code_next[i];
            prio_reg[i] <= prio_next[i];
        end
        if (cmd.load_out)
        begin
            out_code_reg   <= cmd.out_head ? code_reg[0] : '0;
            out_prio_reg   <= cmd.out_head ? prio_reg[0] : '0;
            out_status_reg <= cmd.st;
            out_last_reg   <= cmd.last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg  <= '0;
            remain_reg <= '0;
        end
        else
        begin
            count_reg  <= count_next;
            remain_reg <= remain_next;
        end
    end

    assign out_code     = out_code_reg;
    assign out_priority = out_prio_reg;
    assign out_status   = out_status_reg;
    assign out_last     = out_last_reg;

`ifndef SYNTH
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(DEPTH))
        else $error("entry count beyond depth");

    a_insert_count: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.op == spq_pkg::OP_INSERT) |=> (count_reg == $past(count_reg) + CW'(1)))
        else $error("insert did not grow the queue");

    a_pop_count: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.op == spq_pkg::OP_POP) |=> (count_reg == $past(count_reg) - CW'(1)))
        else $error("pop did not shrink the queue");

    a_head_sorted: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg >= CW'(2) && remain_reg == '0) |-> (prio_reg[0] <= prio_reg[1]))
        else $error("head entries out of order");
`endif

endmodule
